@@ hw/rtl/fde_pkg.sv @@
// fde_pkg: shared types and constants of the factorial divisibility exponent core
// holds field widths, divider operand select and the controller/datapath command
// and status structs; no dependencies
package fde_pkg;

   localparam int FIELD_W = 10;
   localparam int EA_W    = 4;

   typedef enum logic [1:0] {
      DIV_FACTOR,
      DIV_POWER,
      DIV_RATIO
   } div_sel_type;

   typedef struct packed {
      logic        i_init;
      logic        i_inc;
      logic        comp_we;
      logic        comp_mark;
      logic        j_init;
      logic        j_step;
      logic        ptab_we;
      logic        load;
      logic        p_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        a_update;
      logic        t_init;
      logic        t_update;
      logic        best_update;
      logic        idx_inc;
      logic        rsp_load;
   } fde_cmd_type;

   typedef struct packed {
      logic comp_bit;
      logic i_last;
      logic j_over;
      logic jinit_over;
      logic idx_end;
      logic p_over_a;
      logic a_le1;
      logic div_done;
      logic rem_zero;
      logic ea_zero;
      logic t_zero;
      logic rsp_free;
   } fde_stat_type;

endpackage

@@ hw/rtl/factorial_divisibility_exponent_core.sv @@
// factorial_divisibility_exponent_core: largest k with divisor_base^k dividing n_value!
// top level joining fde_ctrl and fde_datapath; depends on fde_pkg
//
// The req channel takes one word (n_value, divisor_base); the rsp channel returns one word
// (max_exponent, unlimited) for each. Words are worked one at a time: req_stall is high
// from acceptance until the result is written into the rsp register.
// For a base of 0 or 1 the result is written with no division. Otherwise one division is
// made for each table prime up to the largest prime factor of the base, one more per
// occurrence of a factor, and one per legendre term plus one for the ratio for each prime
// that divides the base. All of them run on the one shared divider, which yields one
// quotient bit per cycle and serves factoring, legendre and ratio steps.
// After reset the block clears its sieve memory and then runs the sieve to fill the prime
// table; req_stall stays high meanwhile.
// A finished result waits in the rsp register while rsp_stall is high; the next req word
// is already taken, and its result is held back until the register is free.
module factorial_divisibility_exponent_core #(
   parameter int MAX_VALUE   = 1023,
   parameter int PRIME_COUNT = 172
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [fde_pkg::FIELD_W-1:0] req_n_value,
   input  logic [fde_pkg::FIELD_W-1:0] req_divisor_base,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [fde_pkg::FIELD_W-1:0] rsp_max_exponent,
   output logic                        rsp_unlimited
);
   import fde_pkg::*;

   fde_cmd_type  cmd;
   fde_stat_type stat;

   fde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .stat      (stat)
   );

   fde_datapath #(
      .MAX_VALUE   (MAX_VALUE),
      .PRIME_COUNT (PRIME_COUNT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_n_value      (req_n_value),
      .req_divisor_base (req_divisor_base),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_max_exponent (rsp_max_exponent),
      .rsp_unlimited    (rsp_unlimited)
   );

`ifndef ASSERT_OFF
   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("result loaded over a pending word");

   a_unlimited_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_unlimited |-> rsp_max_exponent == '0)
      else $error("unlimited result carries a nonzero exponent");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !cmd.div_start && !cmd.comp_we && !cmd.ptab_we)
      else $error("datapath busy while accepting a word");

   a_factor_exact: assert property (@(posedge clock) disable iff (reset)
      cmd.a_update |-> stat.div_done && stat.rem_zero)
      else $error("base reduced without an exact division");
`endif

endmodule

@@ hw/rtl/fde_ram.sv @@
// fde_ram: generic single write port, single read port ram with registered read
// no dependencies
module fde_ram #(
   parameter int WIDTH  = 1,
   parameter int DEPTH  = 2,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fde_div.sv @@
// fde_div: shared restoring divider, one quotient bit per cycle
// depends on fde_pkg for the dividend width
module fde_div #(
   parameter int DIVISOR_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [fde_pkg::FIELD_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        done,
   output logic [fde_pkg::FIELD_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]        remainder
);
   import fde_pkg::*;

   localparam int CNT_W = $clog2(FIELD_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(FIELD_W - 1);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [FIELD_W-1:0]   quo_ff;
   logic [FIELD_W-1:0]   quo_in;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[FIELD_W-1]};
      diff   = trial - {1'b0, dvs_ff};
      fits   = trial >= {1'b0, dvs_ff};
      quo_in = {quo_ff[FIELD_W-2:0], fits};
      rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

@@ hw/rtl/fde_datapath.sv @@
// fde_datapath: sieve memories, prime table, factoring and legendre registers, result word
// depends on fde_pkg, fde_ram and fde_div
module fde_datapath #(
   parameter int MAX_VALUE   = 1023,
   parameter int PRIME_COUNT = 172
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fde_pkg::fde_cmd_type        cmd,
   output fde_pkg::fde_stat_type       stat,
   input  logic [fde_pkg::FIELD_W-1:0] req_n_value,
   input  logic [fde_pkg::FIELD_W-1:0] req_divisor_base,
   input  logic                        rsp_stall,
   output logic                        rsp_valid,
   output logic [fde_pkg::FIELD_W-1:0] rsp_max_exponent,
   output logic                        rsp_unlimited
);
   import fde_pkg::*;

   localparam int VW  = $clog2(MAX_VALUE + 1);
   localparam int IW  = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
   localparam int FW  = $clog2(PRIME_COUNT + 1);
   localparam int DVW = (VW > EA_W) ? VW : EA_W;
   localparam int CW  = (VW > FIELD_W) ? VW : FIELD_W;

   logic [VW-1:0]      i_ff;
   logic [VW:0]        j_ff;
   logic [FW-1:0]      fill_ff;
   logic [FW-1:0]      idx_ff;
   logic [FIELD_W-1:0] n_ff;
   logic [FIELD_W-1:0] a_ff;
   logic               unl_ff;
   logic [VW-1:0]      p_ff;
   logic [EA_W-1:0]    ea_ff;
   logic [FIELD_W-1:0] t_ff;
   logic [FIELD_W-1:0] sum_ff;
   logic [FIELD_W-1:0] best_ff;
   logic               found_ff;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_exp_ff;
   logic               rsp_unl_ff;

   logic               fill_full;
   logic               comp_rdata;
   logic [VW-1:0]      comp_waddr;
   logic [VW-1:0]      ptab_rdata;
   logic [FIELD_W-1:0] div_dividend;
   logic [DVW-1:0]     div_divisor;
   logic               div_done;
   logic [FIELD_W-1:0] div_quo;
   logic [DVW-1:0]     div_rem;
   logic               q_better;

   // sieve marks, one bit per value
   assign comp_waddr = cmd.comp_mark ? j_ff[VW-1:0] : i_ff;

   fde_ram #(
      .WIDTH (1),
      .DEPTH (MAX_VALUE + 1)
   ) u_comp_ram (
      .clock   (clock),
      .wr_en   (cmd.comp_we),
      .wr_addr (comp_waddr),
      .wr_data (cmd.comp_mark),
      .rd_addr (i_ff),
      .rd_data (comp_rdata)
   );

   assign fill_full = fill_ff == FW'(PRIME_COUNT);

   fde_ram #(
      .WIDTH (VW),
      .DEPTH (PRIME_COUNT)
   ) u_ptab_ram (
      .clock   (clock),
      .wr_en   (cmd.ptab_we && !fill_full),
      .wr_addr (fill_ff[IW-1:0]),
      .wr_data (i_ff),
      .rd_addr (idx_ff[IW-1:0]),
      .rd_data (ptab_rdata)
   );

   always_comb begin
      unique case (cmd.div_sel)
         DIV_FACTOR: begin
            div_dividend = a_ff;
            div_divisor  = DVW'(p_ff);
         end
         DIV_POWER: begin
            div_dividend = t_ff;
            div_divisor  = DVW'(p_ff);
         end
         DIV_RATIO: begin
            div_dividend = sum_ff;
            div_divisor  = DVW'(ea_ff);
         end
         default: begin
            div_dividend = a_ff;
            div_divisor  = DVW'(p_ff);
         end
      endcase
   end

   fde_div #(
      .DIVISOR_W (DVW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign q_better = !found_ff || (div_quo < best_ff);

   always_comb begin
      stat.comp_bit   = comp_rdata;
      stat.i_last     = i_ff == VW'(MAX_VALUE);
      stat.j_over     = (j_ff + {1'b0, i_ff}) > (VW + 1)'(MAX_VALUE);
      stat.jinit_over = ({1'b0, i_ff} + {1'b0, i_ff}) > (VW + 1)'(MAX_VALUE);
      stat.idx_end    = idx_ff == fill_ff;
      stat.p_over_a   = CW'(p_ff) > CW'(a_ff);
      stat.a_le1      = a_ff[FIELD_W-1:1] == '0;
      stat.div_done   = div_done;
      stat.rem_zero   = div_rem == '0;
      stat.ea_zero    = ea_ff == '0;
      stat.t_zero     = t_ff == '0;
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // control counters and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff         <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.i_init) begin
            i_ff    <= VW'(2);
            fill_ff <= '0;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + VW'(1);
         end
         if (cmd.ptab_we && !fill_full) begin
            fill_ff <= fill_ff + FW'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.j_init) begin
         j_ff <= {1'b0, i_ff} + {1'b0, i_ff};
      end else if (cmd.j_step) begin
         j_ff <= j_ff + {1'b0, i_ff};
      end
      if (cmd.load) begin
         n_ff     <= req_n_value;
         a_ff     <= req_divisor_base;
         unl_ff   <= req_divisor_base == FIELD_W'(1);
         idx_ff   <= '0;
         best_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         if (cmd.a_update) begin
            a_ff <= div_quo;
         end
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + FW'(1);
         end
         if (cmd.best_update) begin
            found_ff <= 1'b1;
            if (q_better) begin
               best_ff <= div_quo;
            end
         end
      end
      if (cmd.p_load) begin
         p_ff  <= ptab_rdata;
         ea_ff <= '0;
      end else if (cmd.a_update) begin
         ea_ff <= ea_ff + EA_W'(1);
      end
      if (cmd.t_init) begin
         t_ff   <= n_ff;
         sum_ff <= '0;
      end else if (cmd.t_update) begin
         t_ff   <= div_quo;
         sum_ff <= sum_ff + div_quo;
      end
      if (cmd.rsp_load) begin
         rsp_exp_ff <= best_ff;
         rsp_unl_ff <= unl_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_exponent = rsp_exp_ff;
   assign rsp_unlimited    = rsp_unl_ff;

endmodule

@@ hw/rtl/fde_ctrl.sv @@
// fde_ctrl: sequencer for the reset sieve and the per-word factoring and legendre walk
// depends on fde_pkg
module fde_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output fde_pkg::fde_cmd_type  cmd,
   input  fde_pkg::fde_stat_type stat
);
   import fde_pkg::*;

   typedef enum logic [3:0] {
      S_CLR,
      S_SRD,
      S_STEST,
      S_MARK,
      S_IDLE,
      S_START,
      S_PRD,
      S_PGET,
      S_PCHK,
      S_FDIV,
      S_FNEXT,
      S_LSTART,
      S_LDIV,
      S_QDIV,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLR: begin
            cmd.comp_we = 1'b1;
            if (stat.i_last) begin
               cmd.i_init = 1'b1;
               state_in   = S_SRD;
            end else begin
               cmd.i_inc = 1'b1;
            end
         end
         S_SRD: begin
            state_in = S_STEST;
         end
         S_STEST: begin
            if (!stat.comp_bit) begin
               cmd.ptab_we = 1'b1;
            end
            if (!stat.comp_bit && !stat.jinit_over) begin
               cmd.j_init = 1'b1;
               state_in   = S_MARK;
            end else if (stat.i_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_SRD;
            end
         end
         S_MARK: begin
            cmd.comp_we   = 1'b1;
            cmd.comp_mark = 1'b1;
            if (!stat.j_over) begin
               cmd.j_step = 1'b1;
            end else if (stat.i_last) begin
               state_in = S_IDLE;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_SRD;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            state_in = stat.a_le1 ? S_DONE : S_PRD;
         end
         S_PRD: begin
            state_in = stat.idx_end ? S_DONE : S_PGET;
         end
         S_PGET: begin
            cmd.p_load = 1'b1;
            state_in   = S_PCHK;
         end
         S_PCHK: begin
            if (stat.p_over_a) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_FACTOR;
               state_in      = S_FDIV;
            end
         end
         S_FDIV: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  cmd.a_update = 1'b1;
                  state_in     = S_FNEXT;
               end else if (stat.ea_zero) begin
                  cmd.idx_inc = 1'b1;
                  state_in    = S_PRD;
               end else begin
                  cmd.t_init = 1'b1;
                  state_in   = S_LSTART;
               end
            end
         end
         S_FNEXT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FACTOR;
            state_in      = S_FDIV;
         end
         S_LSTART: begin
            cmd.div_start = 1'b1;
            if (stat.t_zero) begin
               cmd.div_sel = DIV_RATIO;
               state_in    = S_QDIV;
            end else begin
               cmd.div_sel = DIV_POWER;
               state_in    = S_LDIV;
            end
         end
         S_LDIV: begin
            if (stat.div_done) begin
               cmd.t_update = 1'b1;
               state_in     = S_LSTART;
            end
         end
         S_QDIV: begin
            if (stat.div_done) begin
               cmd.best_update = 1'b1;
               cmd.idx_inc     = 1'b1;
               state_in        = S_PRD;
            end
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

endmodule

@@ test/factorial_divisibility_exponent_core_test.sv @@
// factorial_divisibility_exponent_core_test: self-checking bench of the factorial exponent core
// directed table then random words, checked against the table or a sieve-based predictor, with
// random idling on both channels; depends on fde_pkg and factorial_divisibility_exponent_core
module factorial_divisibility_exponent_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fde_pkg::*;

   localparam int MAX_VALUE      = 1023;
   localparam int PRIME_COUNT    = 172;
   localparam int DIRECTED_COUNT = 25;
   localparam int RANDOM_COUNT   = 115;
   localparam int HOLD_AT        = 40;
   localparam int HOLD_CYCLES    = 8000;
   localparam int DRAIN_AT       = 90;
   localparam int QUIET_FROM     = 100;
   localparam int QUIET_TO       = 110;
   localparam int TAIL_CYCLES    = 3000;
   localparam int CYCLE_LIMIT    = 4000000;

   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type max_exponent;
      logic      unlimited;
   } exponent_word_type;

   typedef struct packed {
      field_type n_value;
      field_type divisor_base;
      logic      known;
      field_type max_exponent;
      logic      unlimited;
   } directed_row_type;

   logic      clock = 1'b0;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   field_type req_n_value;
   field_type req_divisor_base;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   field_type rsp_max_exponent;
   logic      rsp_unlimited;

   bit     quiet     = 1'b0;
   bit     long_hold = 1'b0;
   bit     hold_go   = 1'b0;
   int     stall_left = 0;
   int     error_count = 0;

   int unsigned       prime_list[$];
   exponent_word_type pending_exponents[$];

   directed_row_type directed_rows [DIRECTED_COUNT] = '{
      '{10'd0,    10'd1,    1'b1, 10'd0, 1'b1},
      '{10'd1023, 10'd1,    1'b1, 10'd0, 1'b1},
      '{10'd0,    10'd0,    1'b1, 10'd0, 1'b0},
      '{10'd1023, 10'd0,    1'b1, 10'd0, 1'b0},
      '{10'd0,    10'd2,    1'b1, 10'd0, 1'b0},
      '{10'd1,    10'd1023, 1'b1, 10'd0, 1'b0},
      '{10'd0,    10'd1023, 1'b1, 10'd0, 1'b0},
      '{10'd1,    10'd2,    1'b1, 10'd0, 1'b0},
      '{10'd2,    10'd2,    1'b1, 10'd1, 1'b0},
      '{10'd1023, 10'd2,    1'b0, 10'd0, 1'b0},
      '{10'd1023, 10'd512,  1'b0, 10'd0, 1'b0},
      '{10'd1023, 10'd1023, 1'b0, 10'd0, 1'b0},
      '{10'd1021, 10'd1021, 1'b1, 10'd1, 1'b0},
      '{10'd1020, 10'd1021, 1'b1, 10'd0, 1'b0},
      '{10'd1023, 10'd1021, 1'b1, 10'd1, 1'b0},
      '{10'd1001, 10'd1001, 1'b0, 10'd0, 1'b0},
      '{10'd100,  10'd1000, 1'b0, 10'd0, 1'b0},
      '{10'd1023, 10'd768,  1'b0, 10'd0, 1'b0},
      '{10'd512,  10'd256,  1'b0, 10'd0, 1'b0},
      '{10'd10,   10'd6,    1'b0, 10'd0, 1'b0},
      '{10'd1023, 10'd961,  1'b0, 10'd0, 1'b0},
      '{10'd682,  10'd341,  1'b0, 10'd0, 1'b0},
      '{10'd341,  10'd682,  1'b0, 10'd0, 1'b0},
      '{10'd5,    10'd4,    1'b0, 10'd0, 1'b0},
      '{10'd999,  10'd997,  1'b0, 10'd0, 1'b0}
   };

   factorial_divisibility_exponent_core #(
      .MAX_VALUE   (MAX_VALUE),
      .PRIME_COUNT (PRIME_COUNT)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_n_value      (req_n_value),
      .req_divisor_base (req_divisor_base),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_max_exponent (rsp_max_exponent),
      .rsp_unlimited    (rsp_unlimited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void sieve_primes();
      bit composite [MAX_VALUE+1];
      prime_list.delete();
      foreach (composite[i]) composite[i] = 1'b0;
      for (int i = 2; i <= MAX_VALUE; i++) begin
         if (!composite[i]) begin
            if (prime_list.size() < PRIME_COUNT) prime_list.push_back(i);
            for (int j = i * i; j <= MAX_VALUE; j += i) composite[j] = 1'b1;
         end
      end
   endfunction

   function automatic exponent_word_type predict_exponent(input field_type n_value,
                                                          input field_type divisor_base);
      exponent_word_type word;
      int unsigned       rest;
      int unsigned       prime;
      int unsigned       base_exp;
      int unsigned       fact_exp;
      int unsigned       least;
      bit                found;
      word  = '0;
      rest  = divisor_base;
      least = 0;
      found = 1'b0;
      if (divisor_base == 1) begin
         word.unlimited = 1'b1;
         return word;
      end
      if (divisor_base == 0) return word;
      for (int i = 0; i < prime_list.size() && rest > 1; i++) begin
         prime    = prime_list[i];
         base_exp = 0;
         while (rest % prime == 0) begin
            rest = rest / prime;
            base_exp++;
         end
         if (base_exp != 0) begin
            // legendre: sum of n over successive prime powers
            fact_exp = 0;
            for (int unsigned pw = prime; pw <= n_value; pw *= prime) fact_exp += n_value / pw;
            if (!found || fact_exp / base_exp < least) least = fact_exp / base_exp;
            found = 1'b1;
         end
      end
      if (found)
         word.max_exponent = (least > MAX_VALUE) ? field_type'(MAX_VALUE) : field_type'(least);
      return word;
   endfunction

   function automatic int idle_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      error_count++;
      if (error_count <= 10)
         $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
   endtask

   task automatic check_exponent_word();
      exponent_word_type want;
      if (pending_exponents.size() == 0) begin
         report_mismatch("unexpected rsp word, max_exponent", -1, rsp_max_exponent);
         return;
      end
      want = pending_exponents.pop_front();
      if (rsp_max_exponent !== want.max_exponent)
         report_mismatch("max_exponent", want.max_exponent, rsp_max_exponent);
      if (rsp_unlimited !== want.unlimited)
         report_mismatch("unlimited", want.unlimited, rsp_unlimited);
   endtask

   task automatic send_word(input field_type n_value, input field_type divisor_base,
                            input bit known, input exponent_word_type known_word);
      req_valid        <= 1'b1;
      req_n_value      <= n_value;
      req_divisor_base <= divisor_base;
      do @(posedge clock); while (req_stall);
      pending_exponents.push_back(known ? known_word : predict_exponent(n_value, divisor_base));
   endtask

   task automatic sender_gap(input bit allowed);
      int gap;
      gap = 0;
      if (allowed && $urandom_range(0, 2) == 0) gap = idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // receiver: checks accepted words and drives rsp_stall
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) check_exponent_word();
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
         stall_left <= idle_length() - 1;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin : receiver_hold
      wait (hold_go);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL factorial_divisibility_exponent_core");
      $finish;
   end

   initial begin : stimulus
      exponent_word_type known_word;
      int unsigned       base;
      int unsigned       prime;
      int unsigned       pick;
      field_type         n_value;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_n_value      = '0;
      req_divisor_base = '0;
      sieve_primes();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         known_word.max_exponent = directed_rows[i].max_exponent;
         known_word.unlimited    = directed_rows[i].unlimited;
         send_word(directed_rows[i].n_value, directed_rows[i].divisor_base,
                   directed_rows[i].known, known_word);
         sender_gap(1'b1);
      end

      for (int k = 0; k < RANDOM_COUNT; k++) begin
         if (k == HOLD_AT) hold_go = 1'b1;
         if (k == DRAIN_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_exponents.size() != 0);
         end
         if (k == QUIET_FROM) quiet <= 1'b1;
         if (k == QUIET_TO) quiet <= 1'b0;

         pick = $urandom_range(0, 99);
         if (pick < 70) n_value = $urandom_range(0, MAX_VALUE);
         else if (pick < 90) n_value = $urandom_range(0, 20);
         else n_value = $urandom_range(1000, MAX_VALUE);

         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            base = $urandom_range(0, 1);
         end else if (pick < 30) begin
            base = prime_list[$urandom_range(0, prime_list.size() - 1)];
         end else if (pick < 45) begin
            prime = prime_list[$urandom_range(0, 10)];
            base  = prime;
            repeat ($urandom_range(1, 9)) if (base * prime <= MAX_VALUE) base *= prime;
         end else if (pick < 75) begin
            base = $urandom_range(2, 64);
         end else begin
            base = $urandom_range(0, MAX_VALUE);
         end

         send_word(n_value, field_type'(base), 1'b0, '0);
         sender_gap(!(k >= HOLD_AT && k < HOLD_AT + 6) && !(k >= QUIET_FROM && k < QUIET_TO));
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (pending_exponents.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("PASS factorial_divisibility_exponent_core");
      else
         $display("FAIL factorial_divisibility_exponent_core");
      $finish;
   end

endmodule
